[src/lrgf_pkg.sv]
`default_nettype none

package lrgf_pkg;

  localparam int CFG_W = 9;
  localparam int RUN_W = 25;

  typedef logic [CFG_W-1:0] gap_cnt_t;
  typedef logic [RUN_W-1:0] run_len_t;

endpackage

`default_nettype wire

[src/lrgf_chan_if.sv]
`default_nettype none

interface lrgf_day_if;
  logic valid;
  logic ready;
  logic day_marked;
  logic last_day;

  modport source (output valid, output day_marked, output last_day, input ready);
  modport sink (input valid, input day_marked, input last_day, output ready);
endinterface

interface lrgf_run_if;
  logic                valid;
  logic                ready;
  lrgf_pkg::run_len_t  longest_run;

  modport source (output valid, output longest_run, input ready);
  modport sink (input valid, input longest_run, output ready);
endinterface

`default_nettype wire

[src/lrgf_ring.sv]
`default_nettype none

module lrgf_ring #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q_r;
  logic             byp_r;
  logic [WIDTH-1:0] byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // bypass a write that lands on the entry being read
  always_ff @(posedge clk) begin
    rd_q_r     <= mem[rd_addr];
    byp_r      <= wr_en && (wr_addr == rd_addr);
    byp_data_r <= wr_data;
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

`default_nettype wire

[src/longest_run_with_gap_fills.sv]
`default_nettype none

// Longest run of days with gap fills. One day flag is taken per beat, one beat per
// clock cycle with no bubbles while the result side is ready; a result beat is given
// only for an item with last_day set, in the cycle after that item, and it sits in an
// output register. Input beats are held off while that result waits unaccepted. The
// day numbers of filled gaps sit in a ring memory of MAX_GAPS entries, read ahead
// at the next oldest gap with a write bypass, so that an eviction needs no stall.
// The fill budget is min(allowed_gaps, MAX_GAPS, 511); write cfg_wdata only while idle.
module longest_run_with_gap_fills #(
  parameter int MAX_GAPS = 256,
  parameter int DAY_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  lrgf_day_if.sink                        in_ch,
  lrgf_run_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [lrgf_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int PTR_W = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
  localparam int CAP   = (MAX_GAPS > (1 << lrgf_pkg::CFG_W) - 1) ?
                         (1 << lrgf_pkg::CFG_W) - 1 : MAX_GAPS;
  localparam int WA    = (DAY_BITS > lrgf_pkg::CFG_W) ? DAY_BITS : lrgf_pkg::CFG_W;
  localparam int RW    = ((WA > lrgf_pkg::RUN_W) ? WA : lrgf_pkg::RUN_W) + 1;

  lrgf_pkg::gap_cnt_t allowed_r;
  logic [DAY_BITS-1:0] day_r, day_nxt;
  logic [DAY_BITS-1:0] start_r, start_nxt;
  lrgf_pkg::gap_cnt_t gaps_r, gaps_nxt;
  logic [PTR_W-1:0]    oldest_r, oldest_nxt;
  logic [PTR_W-1:0]    newest_r, newest_nxt;
  logic [DAY_BITS-1:0] best_r, best_nxt;
  logic                out_valid_r;
  lrgf_pkg::run_len_t  out_run_r, out_run_nxt;

  logic                accept;
  lrgf_pkg::gap_cnt_t  fills;
  logic                wr_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [DAY_BITS-1:0] head;
  logic [DAY_BITS-1:0] len;
  lrgf_pkg::gap_cnt_t  unused;
  logic [RW-1:0]       padded;
  logic [RW-1:0]       res;
  logic [RW-1:0]       floor_run;

  assign in_ch.ready        = !out_valid_r || out_ch.ready;
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.longest_run = out_run_r;

  assign fills = (allowed_r > lrgf_pkg::gap_cnt_t'(CAP)) ?
                 lrgf_pkg::gap_cnt_t'(CAP) : allowed_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_GAPS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    day_nxt     = day_r;
    start_nxt   = start_r;
    gaps_nxt    = gaps_r;
    oldest_nxt  = oldest_r;
    newest_nxt  = newest_r;
    best_nxt    = best_r;
    wr_en       = 1'b0;
    len         = '0;
    unused      = '0;
    padded      = '0;
    res         = '0;
    floor_run   = RW'(fills) + RW'(1);
    out_run_nxt = out_run_r;
    if (accept) begin
      day_nxt = day_r + DAY_BITS'(1);
      if (!in_ch.day_marked) begin
        if (gaps_r < fills) begin
          wr_en      = 1'b1;
          newest_nxt = ptr_inc(newest_r);
          gaps_nxt   = gaps_r + lrgf_pkg::gap_cnt_t'(1);
        end else if (gaps_r == '0) begin
          start_nxt = day_nxt;
        end else begin
          start_nxt  = head;
          oldest_nxt = ptr_inc(oldest_r);
          wr_en      = 1'b1;
          newest_nxt = ptr_inc(newest_r);
        end
      end
      len = day_nxt - start_nxt;
      if (len > best_r) begin
        best_nxt = len;
      end
      if (in_ch.last_day) begin
        unused = (gaps_nxt < fills) ? fills - gaps_nxt : '0;
        padded = RW'(len) + RW'(unused);
        res    = RW'(best_nxt);
        if (padded > res) begin
          res = padded;
        end
        if (floor_run > res) begin
          res = floor_run;
        end
        out_run_nxt = res[lrgf_pkg::RUN_W-1:0];
        day_nxt     = '0;
        start_nxt   = '0;
        gaps_nxt    = '0;
        oldest_nxt  = '0;
        newest_nxt  = '0;
        best_nxt    = '0;
      end
    end
  end

  assign rd_addr = rst_n ? oldest_nxt : '0;

  lrgf_ring #(
    .DEPTH  (MAX_GAPS),
    .WIDTH  (DAY_BITS),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en && rst_n),
    .wr_addr (newest_r),
    .wr_data (day_nxt),
    .rd_addr (rd_addr),
    .rd_data (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_r   <= '0;
      day_r       <= '0;
      start_r     <= '0;
      gaps_r      <= '0;
      oldest_r    <= '0;
      newest_r    <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        allowed_r <= cfg_wdata;
      end
      day_r    <= day_nxt;
      start_r  <= start_nxt;
      gaps_r   <= gaps_nxt;
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      best_r   <= best_nxt;
      if (accept && in_ch.last_day) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_run_r <= out_run_nxt;
  end

endmodule

`default_nettype wire
